FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that also holds while reset is high.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: design/uartrx_pkg.sv
// Types and constants of the serial receive ring buffer.
package uartrx_pkg;

   localparam int RING_DEPTH_DEFAULT = 256;

   localparam int IDX_W     = 8;
   localparam int DATA_W    = 8;
   localparam int ERR_W     = 4;
   localparam int KIND_W    = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 8;

   localparam logic [KIND_W-1:0] KIND_RX_BYTE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_GET     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FLUSH   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLR_ERR = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_RING_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RX_ENABLE   = 1'b1;

   localparam logic [IDX_W-1:0] RING_LENGTH_RESET = 8'd255;

   // command queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam logic [Q_PTR_W:0] Q_FULL = (Q_PTR_W + 1)'(Q_DEPTH);

   typedef struct packed {
      logic              op_rx;
      logic              op_get;
      logic              op_flush;
      logic              op_clr;
      logic [DATA_W-1:0] data;
      logic [ERR_W-1:0]  errs;
   } cmd_type;

endpackage

FILE: design/uartrx_if.sv
// Channel interfaces: request, response and register write.
interface uartrx_req_if import uartrx_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [DATA_W-1:0] rx_data;
   logic [ERR_W-1:0]  line_errors;
   modport source(output valid, kind, rx_data, line_errors, input ready);
   modport sink(input valid, kind, rx_data, line_errors, output ready);
endinterface

interface uartrx_rsp_if import uartrx_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] out_byte;
   logic              status;
   logic              is_empty;
   logic [ERR_W-1:0]  error_report;
   modport source(output valid, out_byte, status, is_empty, error_report, input ready);
   modport sink(input valid, out_byte, status, is_empty, error_report, output ready);
endinterface

interface uartrx_csr_if import uartrx_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

FILE: design/uartrx_front.sv
// Request front end: decodes the request kind into a queue command.
module uartrx_front import uartrx_pkg::*; (
   uartrx_req_if.sink req_bus,
   output logic       push_valid,
   input  logic       push_ready,
   output cmd_type    push_cmd
);

   always_comb begin
      push_cmd          = '0;
      push_cmd.data     = req_bus.rx_data;
      push_cmd.errs     = req_bus.line_errors;
      case (req_bus.kind)
         KIND_RX_BYTE: push_cmd.op_rx    = 1'b1;
         KIND_GET:     push_cmd.op_get   = 1'b1;
         KIND_FLUSH:   push_cmd.op_flush = 1'b1;
         KIND_CLR_ERR: push_cmd.op_clr   = 1'b1;
         default:      push_cmd.op_clr   = 1'b1;
      endcase
      // payload only matters to received bytes
      if (req_bus.kind != KIND_RX_BYTE) begin
         push_cmd.data = '0;
         push_cmd.errs = '0;
      end
   end

   assign push_valid    = req_bus.valid;
   assign req_bus.ready = push_ready;

endmodule

FILE: design/uartrx_queue.sv
// Short command queue between the front end and the ring engine.
module uartrx_queue import uartrx_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   cmd_type            entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != Q_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: design/uartrx_back.sv
// Ring engine: indices, error latch, byte store, registers and response stage.
module uartrx_back import uartrx_pkg::*; #(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         pop_valid,
   output logic         pop_ready,
   input  cmd_type      pop_cmd,
   uartrx_csr_if.sink   csr_bus,
   uartrx_rsp_if.source rsp_bus
);

   localparam int SLOT_W = $clog2(RING_DEPTH);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);
   localparam logic [IDX_W:0]    DEPTH_LEN = (IDX_W + 1)'(RING_DEPTH);

   logic [DATA_W-1:0] ring_mem [RING_DEPTH];

   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in, wr_idx_ff, wr_idx_in;
   logic [SLOT_W-1:0] rd_slot_ff, rd_slot_in, wr_slot_ff, wr_slot_in;
   logic [ERR_W-1:0]  err_ff, err_in;
   logic [IDX_W-1:0]  len_ff;
   logic              en_ff;

   logic              clr_busy_ff, clr_busy_in;
   logic [SLOT_W-1:0] clr_slot_ff, clr_slot_in, clr_last_ff, clr_last_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              status_ff, status_in;
   logic              empty_ff, empty_in;
   logic [ERR_W-1:0]  report_ff, report_in;
   logic              sel_ff, sel_in;
   logic [DATA_W-1:0] rd_data_ff;

   logic              pop, empty_now, do_write, do_read;
   logic [IDX_W-1:0]  rd_inc, wr_inc, rd_adv, wr_adv;

   assign pop       = pop_valid && pop_ready;
   assign pop_ready = (!rsp_valid_ff || rsp_bus.ready) && !clr_busy_ff;
   assign empty_now = (rd_idx_ff == wr_idx_ff);
   assign do_write  = pop_cmd.op_rx && en_ff;
   assign do_read   = pop_cmd.op_get && !empty_now;

   // index wraps once it reaches the ring length
   assign rd_inc = rd_idx_ff + 1'b1;
   assign wr_inc = wr_idx_ff + 1'b1;
   assign rd_adv = (rd_inc >= len_ff) ? '0 : rd_inc;
   assign wr_adv = (wr_inc >= len_ff) ? '0 : wr_inc;

   always_comb begin
      rd_idx_in    = rd_idx_ff;
      wr_idx_in    = wr_idx_ff;
      rd_slot_in   = rd_slot_ff;
      wr_slot_in   = wr_slot_ff;
      err_in       = err_ff;
      clr_busy_in  = clr_busy_ff;
      clr_slot_in  = clr_slot_ff;
      clr_last_in  = clr_last_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      empty_in     = empty_ff;
      report_in    = report_ff;
      sel_in       = sel_ff;
      if (clr_busy_ff) begin
         if (clr_slot_ff == clr_last_ff) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_slot_in = clr_slot_ff + 1'b1;
         end
      end
      if (pop) begin
         if (do_write) begin
            wr_idx_in = wr_adv;
            // slot tracks index mod depth; a nonzero advance is a plain +1
            if (wr_adv == '0) begin
               wr_slot_in = '0;
            end else begin
               wr_slot_in = (wr_slot_ff == SLOT_LAST) ? '0 : wr_slot_ff + 1'b1;
            end
            if (pop_cmd.errs != '0) begin
               err_in = pop_cmd.errs;
            end
         end
         if (do_read) begin
            rd_idx_in = rd_adv;
            if (rd_adv == '0) begin
               rd_slot_in = '0;
            end else begin
               rd_slot_in = (rd_slot_ff == SLOT_LAST) ? '0 : rd_slot_ff + 1'b1;
            end
         end
         if (pop_cmd.op_flush) begin
            rd_idx_in  = '0;
            wr_idx_in  = '0;
            rd_slot_in = '0;
            wr_slot_in = '0;
            // zero the entries below the ring length, one per cycle
            clr_busy_in = (len_ff != '0);
            clr_slot_in = '0;
            clr_last_in = ({1'b0, len_ff} >= DEPTH_LEN) ? SLOT_LAST : SLOT_W'(len_ff - 1'b1);
         end
         if (pop_cmd.op_clr) begin
            err_in = '0;
         end
         rsp_valid_in = 1'b1;
         status_in    = pop_cmd.op_get && empty_now;
         empty_in     = (rd_idx_in == wr_idx_in);
         report_in    = err_ff;
         sel_in       = do_read;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         rd_slot_ff   <= '0;
         wr_slot_ff   <= '0;
         err_ff       <= '0;
         clr_busy_ff  <= 1'b0;
         clr_slot_ff  <= '0;
         clr_last_ff  <= '0;
         len_ff       <= RING_LENGTH_RESET;
         en_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_idx_ff    <= rd_idx_in;
         wr_idx_ff    <= wr_idx_in;
         rd_slot_ff   <= rd_slot_in;
         wr_slot_ff   <= wr_slot_in;
         err_ff       <= err_in;
         clr_busy_ff  <= clr_busy_in;
         clr_slot_ff  <= clr_slot_in;
         clr_last_ff  <= clr_last_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid) begin
            case (csr_bus.index)
               CSR_RING_LENGTH: len_ff <= csr_bus.data;
               CSR_RX_ENABLE:   en_ff  <= csr_bus.data[0];
               default:         en_ff  <= en_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      empty_ff  <= empty_in;
      report_ff <= report_in;
      sel_ff    <= sel_in;
   end

   // byte store, registered read; no command is popped while clearing
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         ring_mem[clr_slot_ff] <= '0;
      end else if (pop && do_write) begin
         ring_mem[wr_slot_ff] <= pop_cmd.data;
      end
      if (pop && do_read) begin
         rd_data_ff <= ring_mem[rd_slot_ff];
      end
   end

   assign csr_bus.ready        = 1'b1;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.out_byte     = sel_ff ? rd_data_ff : '0;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.is_empty     = empty_ff;
   assign rsp_bus.error_report = report_ff;

endmodule

FILE: design/uart_rx_ring_buffer.sv
// Top level of the serial receive ring buffer.
//
//   channel   dir   handshake      carries
//   req_bus   in    valid/ready    kind, rx_data, line_errors
//   rsp_bus   out   valid/ready    out_byte, status, is_empty, error_report
//   csr_bus   in    valid/ready    index, data (ring_length, rx_enable)
//
// One request per cycle sustained while responses are taken and no flush is
// clearing the store; a response passes through the queue entry and then the
// ring engine's result register after its request is taken.
// The ring engine does one command per cycle with a single store port, unless
// a response stalls; after a flush it zeroes the store one entry at a time
// (ring_length entries, at most RING_DEPTH) and takes no command meanwhile.
// Synchronous reset clears indices, error latch and queue; the byte store is
// not cleared and holds unknown data until written or zeroed by a flush.
// A stalled response holds the engine; the two-entry queue then fills and
// req_bus.ready drops.
module uart_rx_ring_buffer import uartrx_pkg::*; #(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   uartrx_req_if.sink   req_bus,
   uartrx_rsp_if.source rsp_bus,
   uartrx_csr_if.sink   csr_bus
);

   logic    push_valid, push_ready, pop_valid, pop_ready;
   cmd_type push_cmd, pop_cmd;

   uartrx_front u_front (
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   uartrx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   uartrx_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .csr_bus    (csr_bus),
      .rsp_bus    (rsp_bus)
   );

endmodule

FILE: design/uartrx_checker.sv
// Port-level checks of the ring buffer and their bind to the top level.
`include "assert_macros.svh"

module uartrx_checker import uartrx_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DATA_W-1:0] rsp_out_byte,
   input logic              rsp_status,
   input logic              rsp_is_empty,
   input logic [ERR_W-1:0]  rsp_error_report
);

   // no response right after reset
   `ASSERT_NEXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_valid)

   // a refused get leaves the ring empty and returns no byte
   `ASSERT_IMPLY(a_refused_get, clock, reset, rsp_valid && rsp_status, rsp_is_empty && (rsp_out_byte == '0))

   `ASSERT_NEXT(a_stall_valid, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   `ASSERT_NEXT(a_stall_data, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_out_byte) && $stable(rsp_error_report) && $stable(rsp_status))

endmodule

bind uart_rx_ring_buffer uartrx_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_out_byte     (rsp_bus.out_byte),
   .rsp_status       (rsp_bus.status),
   .rsp_is_empty     (rsp_bus.is_empty),
   .rsp_error_report (rsp_bus.error_report)
);
